FILE: hw/rtl/sm83_pkg.sv
// Shared types and constants for the SM83 subset core.
// Holds ALU request/response structs, opcode codes and reset values.
// No dependencies.
package sm83_pkg;

   // request command codes
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_EXEC = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   // response status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_BAD     = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;

   // 8-bit register index in opcode fields
   localparam logic [2:0] REG_B   = 3'd0;
   localparam logic [2:0] REG_C   = 3'd1;
   localparam logic [2:0] REG_D   = 3'd2;
   localparam logic [2:0] REG_E   = 3'd3;
   localparam logic [2:0] REG_H   = 3'd4;
   localparam logic [2:0] REG_L   = 3'd5;
   localparam logic [2:0] REG_MEM = 3'd6;
   localparam logic [2:0] REG_A   = 3'd7;

   // reset values
   localparam logic [7:0]  A_RESET  = 8'h01;
   localparam logic [7:0]  F_RESET  = 8'hB0;
   localparam logic [7:0]  B_RESET  = 8'h00;
   localparam logic [7:0]  C_RESET  = 8'h13;
   localparam logic [7:0]  D_RESET  = 8'h00;
   localparam logic [7:0]  E_RESET  = 8'hD8;
   localparam logic [7:0]  H_RESET  = 8'h01;
   localparam logic [7:0]  L_RESET  = 8'h4D;
   localparam logic [15:0] SP_RESET = 16'hFFFE;
   localparam logic [15:0] PC_RESET = 16'h0100;
   localparam logic [7:0]  IO_PAGE  = 8'hFF;
   localparam logic [7:0]  F_MASK   = 8'hF0;

   // opcodes
   localparam logic [7:0] OP_NOP      = 8'h00;
   localparam logic [7:0] OP_DI       = 8'hF3;
   localparam logic [7:0] OP_RRCA     = 8'h0F;
   localparam logic [7:0] OP_RRA      = 8'h1F;
   localparam logic [7:0] OP_LD_BC_A  = 8'h02;
   localparam logic [7:0] OP_LD_A_BC  = 8'h0A;
   localparam logic [7:0] OP_LD_DE_A  = 8'h12;
   localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
   localparam logic [7:0] OP_LD_B_N   = 8'h06;
   localparam logic [7:0] OP_LD_C_N   = 8'h0E;
   localparam logic [7:0] OP_LD_D_N   = 8'h16;
   localparam logic [7:0] OP_LD_E_N   = 8'h1E;
   localparam logic [7:0] OP_LD_H_N   = 8'h26;
   localparam logic [7:0] OP_LD_L_N   = 8'h2E;
   localparam logic [7:0] OP_LD_M_N   = 8'h36;
   localparam logic [7:0] OP_LD_A_N   = 8'h3E;
   localparam logic [7:0] OP_LDI_M_A  = 8'h22;
   localparam logic [7:0] OP_LDI_A_M  = 8'h2A;
   localparam logic [7:0] OP_LDD_M_A  = 8'h32;
   localparam logic [7:0] OP_LDD_A_M  = 8'h3A;
   localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
   localparam logic [7:0] OP_LDH_C_A  = 8'hE2;
   localparam logic [7:0] OP_LD_NN_A  = 8'hEA;
   localparam logic [7:0] OP_LDH_A_N  = 8'hF0;
   localparam logic [7:0] OP_LDH_A_C  = 8'hF2;
   localparam logic [7:0] OP_LD_A_NN  = 8'hFA;
   localparam logic [7:0] OP_LD_BC_NN = 8'h01;
   localparam logic [7:0] OP_LD_DE_NN = 8'h11;
   localparam logic [7:0] OP_LD_HL_NN = 8'h21;
   localparam logic [7:0] OP_LD_SP_NN = 8'h31;
   localparam logic [7:0] OP_POP_BC   = 8'hC1;
   localparam logic [7:0] OP_POP_DE   = 8'hD1;
   localparam logic [7:0] OP_POP_HL   = 8'hE1;
   localparam logic [7:0] OP_POP_AF   = 8'hF1;
   localparam logic [7:0] OP_PUSH_BC  = 8'hC5;
   localparam logic [7:0] OP_PUSH_DE  = 8'hD5;
   localparam logic [7:0] OP_PUSH_HL  = 8'hE5;
   localparam logic [7:0] OP_PUSH_AF  = 8'hF5;
   localparam logic [7:0] OP_LD_NN_SP = 8'h08;
   localparam logic [7:0] OP_LD_SP_HL = 8'hF9;
   localparam logic [7:0] OP_INC_D    = 8'h14;
   localparam logic [7:0] OP_INC_E    = 8'h1C;
   localparam logic [7:0] OP_INC_H    = 8'h24;
   localparam logic [7:0] OP_INC_L    = 8'h2C;
   localparam logic [7:0] OP_INC_A    = 8'h3C;
   localparam logic [7:0] OP_DEC_B    = 8'h05;
   localparam logic [7:0] OP_DEC_C    = 8'h0D;
   localparam logic [7:0] OP_DEC_E    = 8'h1D;
   localparam logic [7:0] OP_DEC_H    = 8'h25;
   localparam logic [7:0] OP_DEC_L    = 8'h2D;
   localparam logic [7:0] OP_DEC_M    = 8'h35;
   localparam logic [7:0] OP_DEC_A    = 8'h3D;
   localparam logic [7:0] OP_ADD_N    = 8'hC6;
   localparam logic [7:0] OP_ADC_N    = 8'hCE;
   localparam logic [7:0] OP_SUB_N    = 8'hD6;
   localparam logic [7:0] OP_CP_N     = 8'hFE;
   localparam logic [7:0] OP_OR_B     = 8'hB0;
   localparam logic [7:0] OP_OR_C     = 8'hB1;
   localparam logic [7:0] OP_OR_M     = 8'hB6;
   localparam logic [7:0] OP_OR_A     = 8'hB7;
   localparam logic [7:0] OP_XOR_C    = 8'hA9;
   localparam logic [7:0] OP_XOR_L    = 8'hAD;
   localparam logic [7:0] OP_XOR_M    = 8'hAE;
   localparam logic [7:0] OP_XOR_A    = 8'hAF;
   localparam logic [7:0] OP_XOR_N    = 8'hEE;
   localparam logic [7:0] OP_AND_N    = 8'hE6;
   localparam logic [7:0] OP_INC_BC   = 8'h03;
   localparam logic [7:0] OP_INC_DE   = 8'h13;
   localparam logic [7:0] OP_INC_HL   = 8'h23;
   localparam logic [7:0] OP_ADD_HLHL = 8'h29;
   localparam logic [7:0] OP_JR       = 8'h18;
   localparam logic [7:0] OP_JR_NZ    = 8'h20;
   localparam logic [7:0] OP_JR_Z     = 8'h28;
   localparam logic [7:0] OP_JR_NC    = 8'h30;
   localparam logic [7:0] OP_JR_C     = 8'h38;
   localparam logic [7:0] OP_JP       = 8'hC3;
   localparam logic [7:0] OP_CALL_NZ  = 8'hC4;
   localparam logic [7:0] OP_CALL     = 8'hCD;
   localparam logic [7:0] OP_RET_Z    = 8'hC8;
   localparam logic [7:0] OP_RET      = 8'hC9;
   localparam logic [7:0] OP_RET_NC   = 8'hD0;
   localparam logic [7:0] OP_RET_C    = 8'hD8;
   localparam logic [7:0] OP_JP_HL    = 8'hE9;
   localparam logic [7:0] OP_PREFIX   = 8'hCB;
   localparam logic [7:0] OP_HALT     = 8'h76;

   // CB sub-opcodes
   localparam logic [7:0] CB_RR_C  = 8'h19;
   localparam logic [7:0] CB_RR_D  = 8'h1A;
   localparam logic [7:0] CB_RR_E  = 8'h1B;
   localparam logic [7:0] CB_SRL_B = 8'h38;

   typedef enum logic [3:0] {
      ALU_ADD, ALU_ADC, ALU_SUB, ALU_INC, ALU_DEC,
      ALU_AND, ALU_OR, ALU_XOR, ALU_SHR
   } alu_kind_type;

   typedef struct packed {
      alu_kind_type kind;
      logic [7:0]   a;
      logic [7:0]   b;
      logic [7:0]   flags;
      logic         top;
      logic         zclr;
   } alu_req_type;

   typedef struct packed {
      logic [7:0] res;
      logic [7:0] flags;
   } alu_rsp_type;

   // number of immediate bytes after the opcode (prefix sub-opcode counts)
   function automatic logic [1:0] imm_count(input logic [7:0] op);
      logic [1:0] n;
      n = 2'd0;
      unique case (op)
         OP_LD_B_N, OP_LD_C_N, OP_LD_D_N, OP_LD_E_N, OP_LD_H_N, OP_LD_L_N,
         OP_LD_M_N, OP_LD_A_N, OP_LDH_N_A, OP_LDH_A_N, OP_ADD_N, OP_ADC_N,
         OP_SUB_N, OP_CP_N, OP_XOR_N, OP_AND_N, OP_JR, OP_JR_NZ, OP_JR_Z,
         OP_JR_NC, OP_JR_C, OP_PREFIX:
            n = 2'd1;
         OP_LD_BC_NN, OP_LD_DE_NN, OP_LD_HL_NN, OP_LD_SP_NN, OP_LD_NN_A,
         OP_LD_A_NN, OP_LD_NN_SP, OP_JP, OP_CALL_NZ, OP_CALL:
            n = 2'd2;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

   // 8-bit register select; memory index reads as zero (caller fetches it)
   function automatic logic [7:0] sel8(input logic [2:0] idx,
                                       input logic [7:0] b, input logic [7:0] c,
                                       input logic [7:0] d, input logic [7:0] e,
                                       input logic [7:0] h, input logic [7:0] l,
                                       input logic [7:0] a);
      logic [7:0] v;
      unique case (idx)
         REG_B:   v = b;
         REG_C:   v = c;
         REG_D:   v = d;
         REG_E:   v = e;
         REG_H:   v = h;
         REG_L:   v = l;
         REG_MEM: v = 8'h00;
         REG_A:   v = a;
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/sm83_mem.sv
// Byte memory for the SM83 subset core: one port, registered read.
// No dependencies beyond the address width parameter.
module sm83_mem #(
   parameter int ADDR_BITS = 16
) (
   input  logic                 clock,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic                 we,
   input  logic [7:0]           wdata,
   output logic [7:0]           rdata
);
   logic [7:0] mem [0:(1 << ADDR_BITS)-1];

   // write or read; read data is registered and comes out in the next cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

FILE: hw/rtl/sm83_alu.sv
// 8-bit ALU of the SM83 subset core: add, subtract, logic, right shifts.
// Depends on sm83_pkg for the request and response structs.
module sm83_alu (
   input  sm83_pkg::alu_req_type req,
   output sm83_pkg::alu_rsp_type rsp
);
   import sm83_pkg::*;

   logic [8:0] t;
   logic [7:0] bop;
   logic       cin;
   logic       is_sub;
   logic       keep_c;
   logic       z;

   always_comb begin
      bop    = req.b;
      cin    = 1'b0;
      is_sub = 1'b0;
      keep_c = 1'b0;
      t      = 9'd0;
      z      = 1'b0;
      rsp    = '0;
      unique case (req.kind)
         ALU_ADD, ALU_ADC, ALU_INC: begin
            if (req.kind == ALU_INC) begin
               bop    = 8'h01;
               keep_c = 1'b1;
            end
            if (req.kind == ALU_ADC) begin
               cin = req.flags[4];
            end
            t = {1'b0, req.a} + {1'b0, bop} + {8'h00, cin};
         end
         ALU_SUB, ALU_DEC: begin
            is_sub = 1'b1;
            if (req.kind == ALU_DEC) begin
               bop    = 8'h01;
               keep_c = 1'b1;
            end
            t = {1'b0, req.a} - {1'b0, bop};
         end
         ALU_AND: t = {1'b0, req.a & req.b};
         ALU_OR:  t = {1'b0, req.a | req.b};
         ALU_XOR: t = {1'b0, req.a ^ req.b};
         ALU_SHR: t = {1'b0, req.top, req.a[7:1]};
         default: t = 9'd0;
      endcase
      z       = (t[7:0] == 8'h00);
      rsp.res = t[7:0];
      unique case (req.kind)
         ALU_ADD, ALU_ADC, ALU_INC, ALU_SUB, ALU_DEC: begin
            rsp.flags = {z, is_sub, t[4] ^ req.a[4] ^ bop[4],
                         keep_c ? req.flags[4] : t[8], 4'h0};
         end
         ALU_AND:         rsp.flags = {z, 1'b0, 1'b1, 5'h00};
         ALU_OR, ALU_XOR: rsp.flags = {z, 7'h00};
         ALU_SHR:         rsp.flags = {z & ~req.zclr, 2'b00, req.a[0], 4'h0};
         default:         rsp.flags = 8'h00;
      endcase
   end
endmodule

FILE: hw/rtl/sm83_cpu_core_subset.sv
// Top level of the SM83 subset core: command sequencer and register state.
// Depends on sm83_pkg, sm83_mem and sm83_alu.
//
// Use: one request in, one response out. req_opcode selects a byte load
// into the local memory, a byte read back, or the execution of one
// instruction at the program counter. Every response carries the status,
// the full register file after the request, the read byte and the
// offending opcode when the core stopped.
// Timing: all memory traffic goes through one single-port RAM with a
// registered read, so bytes are fetched and stored one at a time. Each
// request passes S_IDLE and S_RESP; a read adds S_CMDRD, an instruction
// S_OP and S_EXE, plus S_IMM1/S_IMM2 for immediates, S_MEM1/S_MEM2 for
// operand reads and S_WR2 for a second stored byte; CALL, LD A,(nn) and
// LD (nn),SP take longest. The response becomes valid in the same cycle
// that the core is back in S_IDLE and can take the next request.
// One request is in work at a time; req_stall is high while busy. The
// response register holds its result under rsp_stall while the next
// request is taken and worked on; only its completion waits.
// Reset sets the registers to their boot values, clears the stopped flag
// and drops rsp_valid; memory contents are undefined until written.
module sm83_cpu_core_subset #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_mem_addr,
   input  logic [7:0]  req_mem_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_prog_counter,
   output logic [15:0] rsp_stack_ptr,
   output logic [15:0] rsp_acc_flags,
   output logic [15:0] rsp_pair_bc,
   output logic [15:0] rsp_pair_de,
   output logic [15:0] rsp_pair_hl,
   output logic [7:0]  rsp_read_byte,
   output logic [7:0]  rsp_bad_opcode
);
   import sm83_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_CMDRD = 10'b0000000010,
      S_OP    = 10'b0000000100,
      S_IMM1  = 10'b0000001000,
      S_IMM2  = 10'b0000010000,
      S_EXE   = 10'b0000100000,
      S_MEM1  = 10'b0001000000,
      S_MEM2  = 10'b0010000000,
      S_WR2   = 10'b0100000000,
      S_RESP  = 10'b1000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  op_ff, op_in, lo_ff, lo_in, hi_ff, hi_in, wbyte_ff, wbyte_in;
   logic [15:0] wad_ff, wad_in;
   logic [7:0]  a_ff, a_in, f_ff, f_in, b_ff, b_in, c_ff, c_in;
   logic [7:0]  d_ff, d_in, e_ff, e_in, h_ff, h_in, l_ff, l_in;
   logic [15:0] sp_ff, sp_in, pc_ff, pc_in;
   logic        halt_ff, halt_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  rb_ff, rb_in, bad_ff, bad_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_load;

   logic [15:0] m_addr;
   logic        m_we;
   logic [7:0]  m_wdata, m_rdata;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic        rw_en;
   logic [2:0]  rw_idx;
   logic [7:0]  rw_val;

   logic [15:0] hl, bc, de, imm16, pushv, popv, hl2;
   logic [2:0]  src, dst;
   logic        zf, cf, is_move;

   sm83_mem #(.ADDR_BITS(MEM_ADDR_BITS)) u_mem (
      .clock (clock),
      .addr  (m_addr[MEM_ADDR_BITS-1:0]),
      .we    (m_we),
      .wdata (m_wdata),
      .rdata (m_rdata)
   );

   sm83_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign hl      = {h_ff, l_ff};
   assign bc      = {b_ff, c_ff};
   assign de      = {d_ff, e_ff};
   assign imm16   = {hi_ff, lo_ff};
   assign popv    = {m_rdata, lo_ff};
   assign hl2     = {hl[14:0], 1'b0};
   assign src     = op_ff[2:0];
   assign dst     = op_ff[5:3];
   assign zf      = f_ff[7];
   assign cf      = f_ff[4];
   assign is_move = (op_ff[7:6] == 2'b01) && (op_ff != OP_HALT);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_load  = !(rsp_valid_ff && rsp_stall);

   // push value by opcode
   always_comb begin
      unique case (op_ff)
         OP_PUSH_BC: pushv = bc;
         OP_PUSH_DE: pushv = de;
         OP_PUSH_HL: pushv = hl;
         OP_PUSH_AF: pushv = {a_ff, f_ff};
         default:    pushv = pc_ff;
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      wad_in    = wad_ff;
      wbyte_in  = wbyte_ff;
      a_in      = a_ff;
      f_in      = f_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      e_in      = e_ff;
      h_in      = h_ff;
      l_in      = l_ff;
      sp_in     = sp_ff;
      pc_in     = pc_ff;
      halt_in   = halt_ff;
      status_in = status_ff;
      rb_in     = rb_ff;
      bad_in    = bad_ff;
      m_addr    = pc_ff;
      m_we      = 1'b0;
      m_wdata   = a_ff;
      alu_req   = '{kind: ALU_ADD, a: a_ff, b: lo_ff, flags: f_ff, top: 1'b0,
                    zclr: 1'b0};
      rw_en     = 1'b0;
      rw_idx    = dst;
      rw_val    = lo_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = ST_DONE;
               rb_in     = 8'h00;
               bad_in    = 8'h00;
               state_in  = S_RESP;
               unique case (req_opcode)
                  CMD_LOAD: begin
                     m_addr  = req_mem_addr;
                     m_we    = 1'b1;
                     m_wdata = req_mem_data;
                  end
                  CMD_READ: begin
                     m_addr   = req_mem_addr;
                     state_in = S_CMDRD;
                  end
                  CMD_EXEC: begin
                     if (halt_ff) begin
                        status_in = ST_IGNORED;
                     end else begin
                        pc_in    = pc_ff + 16'd1;
                        state_in = S_OP;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end

         S_CMDRD: begin
            rb_in    = m_rdata;
            state_in = S_RESP;
         end

         // opcode arrives; fetch first immediate if any
         S_OP: begin
            op_in = m_rdata;
            if (imm_count(m_rdata) != 2'd0) begin
               pc_in    = pc_ff + 16'd1;
               state_in = S_IMM1;
            end else begin
               state_in = S_EXE;
            end
         end

         S_IMM1: begin
            lo_in = m_rdata;
            if (imm_count(op_ff) == 2'd2) begin
               pc_in    = pc_ff + 16'd1;
               state_in = S_IMM2;
            end else begin
               state_in = S_EXE;
            end
         end

         S_IMM2: begin
            hi_in    = m_rdata;
            state_in = S_EXE;
         end

         // execute: register work, first memory access
         S_EXE: begin
            state_in = S_RESP;
            priority if (is_move) begin
               if (src == REG_MEM) begin
                  m_addr   = hl;
                  state_in = S_MEM1;
               end else if (dst == REG_MEM) begin
                  m_addr  = hl;
                  m_we    = 1'b1;
                  m_wdata = sel8(src, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff, a_ff);
               end else begin
                  rw_en  = 1'b1;
                  rw_val = sel8(src, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff, a_ff);
               end
            end else begin
               unique case (op_ff)
                  OP_NOP, OP_DI: state_in = S_RESP;
                  OP_RRCA, OP_RRA: begin
                     alu_req.kind = ALU_SHR;
                     alu_req.top  = (op_ff == OP_RRCA) ? a_ff[0] : cf;
                     alu_req.zclr = 1'b1;
                     a_in         = alu_rsp.res;
                     f_in         = alu_rsp.flags;
                  end
                  OP_LD_BC_A, OP_LD_DE_A: begin
                     m_addr = (op_ff == OP_LD_BC_A) ? bc : de;
                     m_we   = 1'b1;
                  end
                  OP_LD_A_BC, OP_LD_A_DE: begin
                     m_addr   = (op_ff == OP_LD_A_BC) ? bc : de;
                     state_in = S_MEM1;
                  end
                  OP_LD_B_N, OP_LD_C_N, OP_LD_D_N, OP_LD_E_N, OP_LD_H_N,
                  OP_LD_L_N, OP_LD_M_N, OP_LD_A_N: begin
                     if (dst == REG_MEM) begin
                        m_addr  = hl;
                        m_we    = 1'b1;
                        m_wdata = lo_ff;
                     end else begin
                        rw_en = 1'b1;
                     end
                  end
                  OP_LDI_M_A, OP_LDD_M_A: begin
                     m_addr         = hl;
                     m_we           = 1'b1;
                     {h_in, l_in}   = (op_ff == OP_LDI_M_A) ? hl + 16'd1 : hl - 16'd1;
                  end
                  OP_LDI_A_M, OP_LDD_A_M: begin
                     m_addr         = hl;
                     {h_in, l_in}   = (op_ff == OP_LDI_A_M) ? hl + 16'd1 : hl - 16'd1;
                     state_in       = S_MEM1;
                  end
                  OP_LDH_N_A: begin
                     m_addr = {IO_PAGE, lo_ff};
                     m_we   = 1'b1;
                  end
                  OP_LDH_C_A: begin
                     m_addr = {IO_PAGE, c_ff};
                     m_we   = 1'b1;
                  end
                  OP_LD_NN_A: begin
                     m_addr = imm16;
                     m_we   = 1'b1;
                  end
                  OP_LDH_A_N: begin
                     m_addr   = {IO_PAGE, lo_ff};
                     state_in = S_MEM1;
                  end
                  OP_LDH_A_C: begin
                     m_addr   = {IO_PAGE, c_ff};
                     state_in = S_MEM1;
                  end
                  OP_LD_A_NN: begin
                     m_addr   = imm16;
                     state_in = S_MEM1;
                  end
                  OP_LD_BC_NN: {b_in, c_in} = imm16;
                  OP_LD_DE_NN: {d_in, e_in} = imm16;
                  OP_LD_HL_NN: {h_in, l_in} = imm16;
                  OP_LD_SP_NN: sp_in = imm16;
                  OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF, OP_RET: begin
                     m_addr   = sp_ff;
                     state_in = S_MEM1;
                  end
                  OP_RET_Z, OP_RET_NC, OP_RET_C: begin
                     m_addr = sp_ff;
                     if ((op_ff == OP_RET_Z && zf) || (op_ff == OP_RET_NC && !cf) ||
                         (op_ff == OP_RET_C && cf)) begin
                        state_in = S_MEM1;
                     end
                  end
                  OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF, OP_CALL,
                  OP_CALL_NZ: begin
                     if (op_ff != OP_CALL_NZ || !zf) begin
                        if (op_ff == OP_CALL || op_ff == OP_CALL_NZ) begin
                           pc_in = imm16;
                        end
                        sp_in    = sp_ff - 16'd2;
                        m_addr   = sp_ff - 16'd2;
                        m_we     = 1'b1;
                        m_wdata  = pushv[7:0];
                        wad_in   = sp_ff - 16'd1;
                        wbyte_in = pushv[15:8];
                        state_in = S_WR2;
                     end
                  end
                  OP_LD_NN_SP: begin
                     m_addr   = imm16;
                     m_we     = 1'b1;
                     m_wdata  = sp_ff[7:0];
                     wad_in   = imm16 + 16'd1;
                     wbyte_in = sp_ff[15:8];
                     state_in = S_WR2;
                  end
                  OP_LD_SP_HL: sp_in = hl;
                  OP_JP_HL:    pc_in = hl;
                  OP_INC_D, OP_INC_E, OP_INC_H, OP_INC_L, OP_INC_A,
                  OP_DEC_B, OP_DEC_C, OP_DEC_E, OP_DEC_H, OP_DEC_L, OP_DEC_A: begin
                     alu_req.kind = (op_ff[0]) ? ALU_DEC : ALU_INC;
                     alu_req.a    = sel8(dst, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff, a_ff);
                     rw_en        = 1'b1;
                     rw_val       = alu_rsp.res;
                     f_in         = alu_rsp.flags;
                  end
                  OP_DEC_M: begin
                     m_addr   = hl;
                     state_in = S_MEM1;
                  end
                  OP_ADD_N, OP_ADC_N, OP_SUB_N, OP_CP_N, OP_XOR_N, OP_AND_N: begin
                     unique case (op_ff)
                        OP_ADD_N: alu_req.kind = ALU_ADD;
                        OP_ADC_N: alu_req.kind = ALU_ADC;
                        OP_XOR_N: alu_req.kind = ALU_XOR;
                        OP_AND_N: alu_req.kind = ALU_AND;
                        default:  alu_req.kind = ALU_SUB;
                     endcase
                     if (op_ff != OP_CP_N) begin
                        a_in = alu_rsp.res;
                     end
                     f_in = alu_rsp.flags;
                  end
                  OP_OR_B, OP_OR_C, OP_OR_A, OP_XOR_C, OP_XOR_L, OP_XOR_A: begin
                     alu_req.kind = (op_ff[4]) ? ALU_OR : ALU_XOR;
                     alu_req.b    = sel8(src, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff, a_ff);
                     a_in         = alu_rsp.res;
                     f_in         = alu_rsp.flags;
                  end
                  OP_OR_M, OP_XOR_M: begin
                     m_addr   = hl;
                     state_in = S_MEM1;
                  end
                  OP_INC_BC: {b_in, c_in} = bc + 16'd1;
                  OP_INC_DE: {d_in, e_in} = de + 16'd1;
                  OP_INC_HL: {h_in, l_in} = hl + 16'd1;
                  // ADD HL,HL: half from bit 11, carry from bit 15
                  OP_ADD_HLHL: begin
                     {h_in, l_in} = hl2;
                     f_in         = {zf, 1'b0, hl[11], hl[15], 4'h0};
                  end
                  OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C: begin
                     if (op_ff == OP_JR || (op_ff == OP_JR_NZ && !zf) ||
                         (op_ff == OP_JR_Z && zf) || (op_ff == OP_JR_NC && !cf) ||
                         (op_ff == OP_JR_C && cf)) begin
                        pc_in = pc_ff + {{8{lo_ff[7]}}, lo_ff};
                     end
                  end
                  OP_JP: pc_in = imm16;
                  OP_PREFIX: begin
                     alu_req.kind = ALU_SHR;
                     alu_req.top  = cf;
                     f_in         = alu_rsp.flags;
                     rw_en        = 1'b1;
                     rw_val       = alu_rsp.res;
                     unique case (lo_ff)
                        CB_RR_C: begin
                           rw_idx    = REG_C;
                           alu_req.a = c_ff;
                        end
                        CB_RR_D: begin
                           rw_idx    = REG_D;
                           alu_req.a = d_ff;
                        end
                        CB_RR_E: begin
                           rw_idx    = REG_E;
                           alu_req.a = e_ff;
                        end
                        CB_SRL_B: begin
                           rw_idx      = REG_B;
                           alu_req.a   = b_ff;
                           alu_req.top = 1'b0;
                        end
                        default: begin
                           rw_en     = 1'b0;
                           f_in      = f_ff;
                           bad_in    = lo_ff;
                           halt_in   = 1'b1;
                           status_in = ST_BAD;
                        end
                     endcase
                  end
                  default: begin
                     bad_in    = op_ff;
                     halt_in   = 1'b1;
                     status_in = ST_BAD;
                  end
               endcase
            end
         end

         // memory operand arrived
         S_MEM1: begin
            state_in = S_RESP;
            priority if (is_move) begin
               rw_en  = 1'b1;
               rw_val = m_rdata;
            end else begin
               unique case (op_ff)
                  OP_LD_A_BC, OP_LD_A_DE, OP_LDI_A_M, OP_LDD_A_M, OP_LDH_A_N,
                  OP_LDH_A_C, OP_LD_A_NN:
                     a_in = m_rdata;
                  OP_DEC_M: begin
                     alu_req.kind = ALU_DEC;
                     alu_req.a    = m_rdata;
                     m_addr       = hl;
                     m_we         = 1'b1;
                     m_wdata      = alu_rsp.res;
                     f_in         = alu_rsp.flags;
                  end
                  OP_OR_M, OP_XOR_M: begin
                     alu_req.kind = (op_ff == OP_OR_M) ? ALU_OR : ALU_XOR;
                     alu_req.b    = m_rdata;
                     a_in         = alu_rsp.res;
                     f_in         = alu_rsp.flags;
                  end
                  OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF, OP_RET, OP_RET_Z,
                  OP_RET_NC, OP_RET_C: begin
                     lo_in    = m_rdata;
                     m_addr   = sp_ff + 16'd1;
                     state_in = S_MEM2;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end

         // second pop byte arrived
         S_MEM2: begin
            sp_in    = sp_ff + 16'd2;
            state_in = S_RESP;
            unique case (op_ff)
               OP_POP_BC: {b_in, c_in} = popv;
               OP_POP_DE: {d_in, e_in} = popv;
               OP_POP_HL: {h_in, l_in} = popv;
               OP_POP_AF: begin
                  a_in = popv[15:8];
                  f_in = popv[7:0] & F_MASK;
               end
               default: pc_in = popv;
            endcase
         end

         S_WR2: begin
            m_addr   = wad_ff;
            m_we     = 1'b1;
            m_wdata  = wbyte_ff;
            state_in = S_RESP;
         end

         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // 8-bit register write port
      if (rw_en) begin
         unique case (rw_idx)
            REG_B:   b_in = rw_val;
            REG_C:   c_in = rw_val;
            REG_D:   d_in = rw_val;
            REG_E:   e_in = rw_val;
            REG_H:   h_in = rw_val;
            REG_L:   l_in = rw_val;
            REG_MEM: b_in = b_ff;
            REG_A:   a_in = rw_val;
         endcase
      end
   end

   assign rsp_valid_in = (state_ff == S_RESP && rsp_load) ? 1'b1 :
                         (rsp_stall ? rsp_valid_ff : 1'b0);

   // architectural and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         a_ff         <= A_RESET;
         f_ff         <= F_RESET;
         b_ff         <= B_RESET;
         c_ff         <= C_RESET;
         d_ff         <= D_RESET;
         e_ff         <= E_RESET;
         h_ff         <= H_RESET;
         l_ff         <= L_RESET;
         sp_ff        <= SP_RESET;
         pc_ff        <= PC_RESET;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_ff         <= a_in;
         f_ff         <= f_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         d_ff         <= d_in;
         e_ff         <= e_in;
         h_ff         <= h_in;
         l_ff         <= l_in;
         sp_ff        <= sp_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      wad_ff    <= wad_in;
      wbyte_ff  <= wbyte_in;
      status_ff <= status_in;
      rb_ff     <= rb_in;
      bad_ff    <= bad_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (state_ff == S_RESP && rsp_load) begin
         rsp_status       <= status_ff;
         rsp_prog_counter <= pc_ff;
         rsp_stack_ptr    <= sp_ff;
         rsp_acc_flags    <= {a_ff, f_ff};
         rsp_pair_bc      <= bc;
         rsp_pair_de      <= de;
         rsp_pair_hl      <= hl;
         rsp_read_byte    <= rb_ff;
         rsp_bad_opcode   <= bad_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // the core, once stopped, stays stopped until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("stopped flag cleared without reset");

   // an undefined-opcode response only comes from a stopped core
   a_bad_halted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_BAD) |-> halt_ff)
      else $error("bad opcode reported while core running");

   // memory is never written while waiting to deliver a response
   a_no_wr_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |-> !m_we)
      else $error("memory write during response hold");
endmodule
